>>> hw/rtl/mqrf_pkg.sv
// ----------------------------------------------------------------------------
// mqrf_pkg
// Shared types and constants of the multi-queue ring FIFO: command and result
// words, operation codes and default sizes.
// ----------------------------------------------------------------------------
package mqrf_pkg;

    // Default geometry, handed to the top-level parameters
    localparam int DEPTH_DEF      = 1024;
    localparam int NUM_QUEUES_DEF = 2;

    // Fixed item size and field widths
    localparam int ITEM_BYTES = 1;
    localparam int DATA_W     = 8;
    localparam int FILL_W     = 11;
    localparam int SIZE_W     = 4;
    localparam int QSEL_W     = 2;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_PEEK  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    // One command word
    typedef struct packed {
        t_op                 op;
        logic [QSEL_W-1:0]   queue_sel;
        logic [DATA_W-1:0]   data_in;
        logic [SIZE_W-1:0]   read_size;
    } t_cmd;

    // One result word
    typedef struct packed {
        logic                ok;
        logic [DATA_W-1:0]   data_out;
        logic [FILL_W-1:0]   fill_count;
    } t_result;

endpackage

>>> hw/rtl/multi_queue_ring_fifo.sv
// ----------------------------------------------------------------------------
// multi_queue_ring_fifo
// Several byte FIFOs of power-of-two depth sharing one store RAM.
// ----------------------------------------------------------------------------
// Usage: raise start with a command word; it is taken when busy is low. The
// block takes one command per clock cycle and answers each with exactly one
// result word, shown on o_result with o_strobe high for one cycle, in the
// cycle right after the command was taken. The read data comes from the
// registered read of the shared store RAM: the command cycle updates the
// queue pointers and issues the RAM write (push) or read (pop, peek), and the
// read word leaves the RAM read register. A pop or peek directly after a
// push to the same queue sees the pushed byte, since the write lands at the
// same edge that takes the push. busy is high only while in reset and until
// r_run is set. The receiver cannot stall results, so take every strobe.
// ----------------------------------------------------------------------------
module multi_queue_ring_fifo #(
    parameter int DEPTH      = mqrf_pkg::DEPTH_DEF,
    parameter int NUM_QUEUES = mqrf_pkg::NUM_QUEUES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  mqrf_pkg::t_cmd   i_cmd,
    output logic             o_strobe,
    output mqrf_pkg::t_result o_result
);

    import mqrf_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int PW = IW + 1;
    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int SD = NUM_QUEUES * DEPTH;
    localparam int AW = $clog2(SD);

    logic          r_run;
    logic [PW-1:0] r_wp [NUM_QUEUES];
    logic [PW-1:0] r_rp [NUM_QUEUES];

    logic             accept;
    logic             q_valid;
    logic [QW-1:0]    q_idx;
    logic [PW-1:0]    cur_wp;
    logic [PW-1:0]    cur_rp;
    logic [PW-1:0]    cur_fill;
    logic [PW-1:0]    n_wp;
    logic [PW-1:0]    n_rp;
    logic [PW-1:0]    n_fill;
    logic             n_ok;
    logic             ram_we;
    logic             ram_re;
    logic [IW-1:0]    slot;
    logic [31:0]      addr_full;
    logic [AW-1:0]    ram_addr;
    logic [DATA_W-1:0] ram_q;

    logic              r_strobe;
    logic              r_ok;
    logic              r_rd;
    logic [FILL_W-1:0] r_fill;

    // Hold busy through reset and until the run flag is set
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else begin
            r_run <= 1'b1;
        end
    end

    assign busy   = ~r_run;
    assign accept = start & ~busy;

    // Select the queue and read its pointers
    assign q_valid  = (32'(i_cmd.queue_sel) < 32'(NUM_QUEUES));
    assign q_idx    = QW'(i_cmd.queue_sel);
    assign cur_wp   = q_valid ? r_wp[q_idx] : '0;
    assign cur_rp   = q_valid ? r_rp[q_idx] : '0;
    assign cur_fill = cur_wp - cur_rp;

    // Decide the operation outcome and the next pointers
    always_comb begin
        n_wp   = cur_wp;
        n_rp   = cur_rp;
        n_ok   = 1'b0;
        ram_we = 1'b0;
        ram_re = 1'b0;
        slot   = cur_wp[IW-1:0];
        if (q_valid) begin
            case (i_cmd.op) inside
                OP_PUSH: begin
                    if (cur_fill != PW'(DEPTH)) begin
                        n_wp   = cur_wp + PW'(1);
                        n_ok   = 1'b1;
                        ram_we = accept;
                    end
                end
                OP_POP, OP_PEEK: begin
                    slot = cur_rp[IW-1:0];
                    if (cur_fill != '0 && i_cmd.read_size == SIZE_W'(ITEM_BYTES)) begin
                        n_ok   = 1'b1;
                        ram_re = accept;
                        if (i_cmd.op == OP_POP) begin
                            n_rp = cur_rp + PW'(1);
                        end
                    end
                end
                OP_CLEAR: begin
                    n_wp = '0;
                    n_rp = '0;
                    n_ok = 1'b1;
                end
                default: begin
                    n_ok = 1'b0;
                end
            endcase
        end
    end

    assign n_fill    = n_wp - n_rp;
    assign addr_full = (32'(q_idx) << IW) | 32'(slot);
    assign ram_addr  = addr_full[AW-1:0];

    // Advance the pointers of the selected queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_wp[i] <= '0;
                r_rp[i] <= '0;
            end
        end else if (accept && q_valid) begin
            r_wp[q_idx] <= n_wp;
            r_rp[q_idx] <= n_rp;
        end
    end

    // Shared byte store
    mqrf_ram #(
        .WIDTH (DATA_W),
        .DEPTH (SD)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (i_cmd.data_in),
        .o_rdata (ram_q)
    );

    // Register the result strobe and status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ok   <= n_ok;
            r_rd   <= ram_re;
            r_fill <= q_valid ? FILL_W'(n_fill) : '0;
        end
    end

    // Drive the result word
    always_comb begin
        o_result.ok         = r_ok;
        o_result.data_out   = r_rd ? ram_q : '0;
        o_result.fill_count = r_fill;
    end

    assign o_strobe = r_strobe;

    // Every taken command yields one result in the next cycle
    a_strobe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_strobe)
        else $error("result strobe missing after taken command");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> !o_strobe)
        else $error("result strobe without a taken command");

    // Pointers of a queue never drift more than one depth apart
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && q_valid) |-> (cur_fill <= PW'(DEPTH)))
        else $error("queue fill exceeds depth");

    // Failed commands return zero data
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.ok) |-> (o_result.data_out == '0))
        else $error("failed command returned data");

    // Store is never read and written in the same cycle
    a_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("store read and write collide");

endmodule

>>> hw/rtl/mqrf_ram.sv
// ----------------------------------------------------------------------------
// mqrf_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module mqrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write on enable, register the read word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
